### design/srs_pkg.sv
// types and constants shared by the sack range scoreboard
// no dependencies

package srs_pkg;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
	localparam logic [15:0] SEG_RESET = 16'd536;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] sack_lo;
		logic [31:0] sack_hi;
		logic [31:0] ack_number;
		logic [31:0] query_seq;
	} request_t;

	typedef struct packed {
		logic [31:0] covered_right_edge;
		logic [3:0]  entry_count;
		logic [31:0] sacked_packets;
		logic        overflow;
	} result_t;

	typedef struct packed {
		logic [31:0] le;
		logic [31:0] re;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   data;
	} cell_ctl_t;

endpackage

### design/srs_cell.sv
// one range entry of the scoreboard row, shifts to either neighbor
// depends on srs_pkg

module srs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  srs_pkg::cell_ctl_t ctl,
	input  srs_pkg::entry_t   left_in,
	input  srs_pkg::entry_t   right_in,
	output srs_pkg::entry_t   q
);
	import srs_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			unique case (ctl.op)
				CELL_HOLD:       ent_q <= ent_q;
				CELL_FROM_LEFT:  ent_q <= left_in;
				CELL_FROM_RIGHT: ent_q <= right_in;
				CELL_LOAD:       ent_q <= ctl.data;
				default:         ent_q <= ent_q;
			endcase
		end
	end

	assign q = ent_q;

endmodule

### design/srs_div.sv
// restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// no dependencies

module srs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/sack_range_scoreboard.sv
// sack range scoreboard: busy from the accept edge, result strobe in the first idle cycle
// add, per range: walk and merge over the cell row; tail and bit-serial packet divide
//   unless put ahead, inside or dropped; step; a wrapping range runs this twice; then report
// clear and query: a walk over the cell row, then report
// one item at a time; the next is taken in the strobe cycle; single-cycle strobe, no stall
// asynchronous reset empties the table, zeroes the count, mss to 536

module sack_range_scoreboard #(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  srs_pkg::request_t request,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data,
	output logic              done,
	output srs_pkg::result_t  result
);
	import srs_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WALK  = 4'd1;
	localparam logic [3:0] ST_MERGE = 4'd2;
	localparam logic [3:0] ST_TAIL  = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_SUB   = 4'd5;
	localparam logic [3:0] ST_CLR   = 4'd6;
	localparam logic [3:0] ST_QRY   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_INS  = 2'd1;
	localparam logic [1:0] CMD_REM  = 2'd2;
	localparam logic [1:0] CMD_WR   = 2'd3;

	logic [3:0]    state_q;
	logic [CW-1:0] i_q, n_q, j;
	logic [31:0]   lo_q, hi_q, pend_hi_q, ack_q, seq_q;
	logic          pend_q;
	logic [31:0]   fresh_q, cur_l_q, cur_r_q, edge_q, total_q;
	logic          drop_q;
	logic [15:0]   seg_q;
	logic          done_q;
	result_t       res_q;

	entry_t    cells [TABLE_ENTRIES];
	cell_ctl_t ctl [TABLE_ENTRIES];

	logic [1:0]    cmd_kind;
	logic [CW-1:0] cmd_idx;
	entry_t        cmd_data;
	logic [IW-1:0] rd_idx;
	entry_t        rd;
	logic [31:0]   el, er;
	logic          c_inside, c_before, c_after, full, at_end, j_ok, merge_hit;
	logic [31:0]   fresh_add, fresh_sub, tail_fresh, clr_d;
	logic          clr_hit, q_hit;
	logic          div_start, div_done;
	logic [31:0]   div_quo;
	logic [15:0]   divisor;

	// cell row
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		entry_t lft, rgt;
		if (k == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = cells[k-1];
		end
		if (k == TABLE_ENTRIES - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid_r
			assign rgt = cells[k+1];
		end

		always_comb begin
			ctl[k].data = cmd_data;
			ctl[k].op   = CELL_HOLD;
			unique case (cmd_kind)
				CMD_INS: begin
					if (CW'(k) > cmd_idx)
						ctl[k].op = CELL_FROM_LEFT;
					else if (CW'(k) == cmd_idx)
						ctl[k].op = CELL_LOAD;
				end
				CMD_REM: begin
					if (CW'(k) >= cmd_idx)
						ctl[k].op = CELL_FROM_RIGHT;
				end
				CMD_WR: begin
					if (CW'(k) == cmd_idx)
						ctl[k].op = CELL_LOAD;
				end
				default: ctl[k].op = CELL_HOLD;
			endcase
		end

		srs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[k]),
			.left_in  (lft),
			.right_in (rgt),
			.q        (cells[k])
		);
	end

	assign j = i_q + CW'(1);

	always_comb begin
		if (state_q == ST_MERGE)
			rd_idx = j[IW-1:0];
		else if (state_q == ST_CLR)
			rd_idx = '0;
		else
			rd_idx = i_q[IW-1:0];
	end

	assign rd = cells[rd_idx];
	assign el = rd.le;
	assign er = rd.re;

	assign full      = n_q == FULL;
	assign at_end    = i_q >= n_q;
	assign c_inside  = (lo_q >= el) && (hi_q <= er);
	assign c_before  = hi_q < el;
	assign c_after   = lo_q > er;
	assign j_ok      = j < n_q;
	assign merge_hit = j_ok && (hi_q >= el);
	assign fresh_add = fresh_q + ((lo_q < el) ? el - lo_q : 32'd0)
	                 + ((hi_q > er) ? hi_q - er : 32'd0);
	assign fresh_sub = (hi_q <= er) ? hi_q - el + 32'd1 : er - el + 32'd1;
	assign tail_fresh = (fresh_q == 32'd0) ? hi_q - lo_q + 32'd1 : fresh_q;
	assign clr_d     = ack_q - er;
	assign clr_hit   = (n_q != '0) && (clr_d != 32'd0) && !clr_d[31];
	assign q_hit     = (seq_q >= el) && (seq_q < er);
	assign divisor   = (seg_q == 16'd0) ? 16'd1 : seg_q;
	assign div_start = (state_q == ST_TAIL) && !((fresh_q == 32'd0) && full);

	always_comb begin
		cmd_kind = CMD_NONE;
		cmd_idx  = i_q;
		cmd_data = '{le: lo_q, re: hi_q};
		unique case (state_q)
			ST_WALK: begin
				if (!at_end && !c_inside) begin
					if (c_before) begin
						if (!full)
							cmd_kind = CMD_INS;
					end else if (!c_after && !(hi_q > er)) begin
						cmd_kind = CMD_WR;
						cmd_data = '{le: (lo_q < el) ? lo_q : el, re: er};
					end
				end
			end
			ST_MERGE: begin
				if (merge_hit) begin
					cmd_kind = CMD_REM;
					cmd_idx  = j;
				end else begin
					cmd_kind = CMD_WR;
					cmd_data = '{le: cur_l_q, re: cur_r_q};
				end
			end
			ST_TAIL: begin
				if ((fresh_q == 32'd0) && !full) begin
					cmd_kind = CMD_WR;
					cmd_idx  = n_q;
				end
			end
			ST_CLR: begin
				if (clr_hit) begin
					cmd_kind = CMD_REM;
					cmd_idx  = '0;
				end
			end
			default: cmd_kind = CMD_NONE;
		endcase
	end

	srs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tail_fresh),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			total_q   <= '0;
			seg_q     <= SEG_RESET;
			done_q    <= 1'b0;
			drop_q    <= 1'b0;
			edge_q    <= '0;
			i_q       <= '0;
			fresh_q   <= '0;
			ack_q     <= '0;
			seq_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			pend_hi_q <= '0;
			pend_q    <= 1'b0;
			cur_l_q   <= '0;
			cur_r_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid)
				seg_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						drop_q <= 1'b0;
						edge_q <= '0;
						i_q    <= '0;
						fresh_q <= '0;
						ack_q  <= request.ack_number;
						seq_q  <= request.query_seq;
						lo_q   <= request.sack_lo;
						pend_hi_q <= request.sack_hi;
						if (request.sack_lo <= request.sack_hi) begin
							hi_q   <= request.sack_hi;
							pend_q <= 1'b0;
						end else begin
							hi_q   <= ALL_ONES;
							pend_q <= 1'b1;
						end
						unique case (request.action)
							ACT_ADD:   state_q <= ST_WALK;
							ACT_CLEAR: state_q <= ST_CLR;
							ACT_QUERY: state_q <= ST_QRY;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_WALK: begin
					if (at_end) begin
						state_q <= ST_TAIL;
					end else if (c_inside) begin
						state_q <= ST_SUB;
					end else if (c_before) begin
						if (full)
							drop_q <= 1'b1;
						else
							n_q <= n_q + CW'(1);
						state_q <= ST_SUB;
					end else if (c_after) begin
						i_q <= i_q + CW'(1);
					end else begin
						fresh_q <= fresh_add;
						cur_l_q <= (lo_q < el) ? lo_q : el;
						cur_r_q <= hi_q;
						state_q <= (hi_q > er) ? ST_MERGE : ST_TAIL;
					end
				end
				ST_MERGE: begin
					if (merge_hit) begin
						if (hi_q <= er)
							cur_r_q <= er;
						fresh_q <= fresh_q - fresh_sub;
						n_q     <= n_q - CW'(1);
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if ((fresh_q == 32'd0) && full) begin
						drop_q  <= 1'b1;
						state_q <= ST_SUB;
					end else begin
						if (fresh_q == 32'd0)
							n_q <= n_q + CW'(1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						total_q <= total_q + div_quo;
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					if (pend_q) begin
						pend_q  <= 1'b0;
						lo_q    <= '0;
						hi_q    <= pend_hi_q;
						i_q     <= '0;
						fresh_q <= '0;
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CLR: begin
					if (clr_hit)
						n_q <= n_q - CW'(1);
					else
						state_q <= ST_FIN;
				end
				ST_QRY: begin
					if (at_end) begin
						state_q <= ST_FIN;
					end else if (q_hit) begin
						edge_q  <= er;
						state_q <= ST_FIN;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			res_q.covered_right_edge <= edge_q;
			res_q.entry_count        <= 4'(n_q);
			res_q.sacked_packets     <= total_q;
			res_q.overflow           <= drop_q;
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

endmodule

### design/srs_checker.sv
// port-level checks for the sack range scoreboard, bound to the top level
// depends on srs_pkg and sack_range_scoreboard

module srs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input srs_pkg::result_t  result
);
	import srs_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without result word");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result word has unknown bits");

endmodule

bind sack_range_scoreboard srs_checker u_srs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

### sim/sack_range_scoreboard_tb.sv
// self-checking testbench for sack_range_scoreboard: directed and random add, clear,
// query and nop words with bursty start timing, checked against an in-bench range table model
// depends on srs_pkg and the sack_range_scoreboard rtl

module sack_range_scoreboard_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srs_pkg::*;

	localparam int DEPTH = 8;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [15:0] cfg_data;
	request_t request;
	result_t result;

	sack_range_scoreboard #(.TABLE_ENTRIES(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	request_t word_q[$];
	result_t want_q[$];
	logic [31:0] sb_left[DEPTH], sb_right[DEPTH];
	logic [31:0] sb_total, sb_count;
	logic [15:0] sb_mss;
	bit sb_dropped, accepted, hold_off, failed;
	int burst_left, gap_left;
	logic [31:0] base;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	function automatic void count_bytes(input logic [31:0] bytes);
		logic [31:0] d;
		d = (sb_mss == 0) ? 32'd1 : {16'd0, sb_mss};
		sb_total = sb_total + bytes / d;
	endfunction

	function automatic void add_range(input logic [31:0] lo, input logic [31:0] hi);
		logic [31:0] n, fresh, merged, el, er, jl, jr;
		int i, j, k;
		n = sb_count;
		fresh = 0;
		for (i = 0; i < n; i++) begin
			el = sb_left[i];
			er = sb_right[i];
			if (lo >= el && hi <= er) return;
			if (hi < el) begin
				if (n >= DEPTH) begin
					sb_dropped = 1;
					return;
				end
				for (k = n; k > i; k--) begin
					sb_left[k] = sb_left[k-1];
					sb_right[k] = sb_right[k-1];
				end
				sb_left[i] = lo;
				sb_right[i] = hi;
				sb_count = n + 1;
				return;
			end
			if (lo > er) continue;
			if (lo < el) begin
				fresh = fresh + (el - lo);
				sb_left[i] = lo;
			end
			if (hi > er) begin
				merged = 0;
				fresh = fresh + (hi - er);
				sb_right[i] = hi;
				for (j = i + 1; j < n; j++) begin
					jl = sb_left[j];
					jr = sb_right[j];
					if (hi >= jl) begin
						merged++;
						if (hi <= jr) begin
							sb_right[i] = jr;
							fresh = fresh - (hi - jl + 1);
						end else begin
							fresh = fresh - (jr - jl + 1);
						end
					end else begin
						break;
					end
				end
				if (merged > 0) begin
					for (k = j; k < n; k++) begin
						sb_left[i + 1 + k - j] = sb_left[k];
						sb_right[i + 1 + k - j] = sb_right[k];
					end
					for (k = n - merged; k < n; k++) begin
						sb_left[k] = 0;
						sb_right[k] = 0;
					end
					sb_count = n - merged;
				end
			end
			break;
		end
		if (fresh == 0) begin
			if (sb_count >= DEPTH) begin
				sb_dropped = 1;
				return;
			end
			sb_left[sb_count] = lo;
			sb_right[sb_count] = hi;
			sb_count++;
			fresh = hi - lo + 1;
		end
		count_bytes(fresh);
	endfunction

	function automatic void clear_below(input logic [31:0] ack);
		logic [31:0] d;
		int i, k, n;
		n = sb_count;
		for (i = 0; i < n; i++) begin
			d = ack - sb_right[i];
			if (!(d != 0 && d < 32'h8000_0000)) break;
		end
		if (i == 0) return;
		for (k = i; k < n; k++) begin
			sb_left[k-i] = sb_left[k];
			sb_right[k-i] = sb_right[k];
		end
		for (k = n - i; k < n; k++) begin
			sb_left[k] = 0;
			sb_right[k] = 0;
		end
		sb_count = n - i;
	endfunction

	function automatic result_t predict_sack(input request_t w);
		result_t r;
		logic [31:0] edge_hit;
		edge_hit = 0;
		sb_dropped = 0;
		unique case (w.action)
			ACT_ADD: begin
				if (w.sack_lo <= w.sack_hi) begin
					add_range(w.sack_lo, w.sack_hi);
				end else begin
					add_range(w.sack_lo, ALL_ONES);
					add_range(0, w.sack_hi);
				end
			end
			ACT_CLEAR: clear_below(w.ack_number);
			ACT_QUERY: begin
				for (int i = 0; i < sb_count; i++) begin
					if (w.query_seq >= sb_left[i] && w.query_seq < sb_right[i]) begin
						edge_hit = sb_right[i];
						break;
					end
				end
			end
			default: ;
		endcase
		r.covered_right_edge = edge_hit;
		r.entry_count = sb_count[3:0];
		r.sacked_packets = sb_total;
		r.overflow = sb_dropped;
		return r;
	endfunction

	function automatic request_t mk(input logic [1:0] a, input logic [31:0] l,
			input logic [31:0] r, input logic [31:0] k, input logic [31:0] q);
		request_t w;
		w.action = a;
		w.sack_lo = l;
		w.sack_hi = r;
		w.ack_number = k;
		w.query_seq = q;
		return w;
	endfunction

	function automatic request_t rand_word();
		logic [31:0] lo, hi, t;
		int p;
		p = $urandom_range(0, 99);
		if ($urandom_range(0, 30) == 0) base = $urandom_range(0, 4) == 0 ? 32'hFFFF_E000 : $urandom;
		lo = base + $urandom_range(0, 6000);
		hi = lo + $urandom_range(0, 1500);
		if (p < 55) begin
			if ($urandom_range(0, 19) == 0) begin
				t = lo;
				lo = hi;
				hi = t;
			end
			if ($urandom_range(0, 19) == 0) begin
				lo = $urandom;
				hi = $urandom;
			end
			return mk(ACT_ADD, lo, hi, $urandom, $urandom);
		end
		if (p < 70)
			return mk(ACT_CLEAR, $urandom, $urandom,
				$urandom_range(0, 9) == 0 ? $urandom : base + $urandom_range(0, 7000), $urandom);
		if (p < 92)
			return mk(ACT_QUERY, $urandom, $urandom, $urandom,
				$urandom_range(0, 9) == 0 ? $urandom : lo);
		return mk(ACT_NOP, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// monitor: check results, then predict newly accepted words
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (want_q.size() == 0) begin
					$display("%0t unexpected result %h", $time, result);
					failed = 1;
				end else begin
					want = want_q.pop_front();
					if (result.covered_right_edge !== want.covered_right_edge)
						$display("%0t covered_right_edge exp %h got %h", $time,
							want.covered_right_edge, result.covered_right_edge);
					if (result.entry_count !== want.entry_count)
						$display("%0t entry_count exp %0d got %0d", $time,
							want.entry_count, result.entry_count);
					if (result.sacked_packets !== want.sacked_packets)
						$display("%0t sacked_packets exp %0d got %0d", $time,
							want.sacked_packets, result.sacked_packets);
					if (result.overflow !== want.overflow)
						$display("%0t overflow exp %b got %b", $time,
							want.overflow, result.overflow);
					if (result !== want) failed = 1;
				end
			end
			if (start && !busy) want_q.push_back(predict_sack(request));
			accepted <= start && !busy;
		end
	end

	// driver: bursts of words with random gaps
	always @(negedge clk) begin
		bit go;
		if (arst_n) begin
			go = start;
			if (accepted && start) begin
				void'(word_q.pop_front());
				go = 0;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!hold_off && word_q.size() > 0) begin
					request <= word_q[0];
					go = 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
					end else begin
						burst_left--;
					end
				end
			end
			start <= go;
		end
	end

	task automatic drain();
		while (word_q.size() > 0 || start || want_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mss(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb_mss = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		logic [15:0] mss_set[5];
		mss_set = '{16'd1, 16'd65535, 16'd1460, 16'd0, 16'd100};
		arst_n = 0;
		start = 0;
		request = '0;
		cfg_valid = 0;
		cfg_data = '0;
		accepted = 0;
		hold_off = 0;
		failed = 0;
		burst_left = 0;
		gap_left = 0;
		base = 32'd1000;
		sb_total = 0;
		sb_count = 0;
		sb_mss = SEG_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			sb_left[i] = 0;
			sb_right[i] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		word_q.push_back(mk(ACT_QUERY, 0, 0, 0, 0));
		word_q.push_back(mk(ACT_ADD, 5000, 6999, 0, 0));
		word_q.push_back(mk(ACT_ADD, 5100, 5200, 0, 0));
		word_q.push_back(mk(ACT_ADD, 1000, 1999, 0, 0));
		word_q.push_back(mk(ACT_ADD, 9000, 9999, 0, 0));
		word_q.push_back(mk(ACT_ADD, 1500, 9500, 0, 0));
		word_q.push_back(mk(ACT_ADD, ALL_ONES - 600, 400, 0, 0));
		word_q.push_back(mk(ACT_ADD, ALL_ONES, ALL_ONES, 0, 0));
		for (int i = 0; i < 8; i++)
			word_q.push_back(mk(ACT_ADD, 20000 + i * 3000, 20000 + i * 3000 + 999, 0, 0));
		word_q.push_back(mk(ACT_ADD, 15000, 15010, 0, 0));
		word_q.push_back(mk(ACT_QUERY, 0, 0, 0, 21500));
		word_q.push_back(mk(ACT_QUERY, 0, 0, 0, 22999));
		word_q.push_back(mk(ACT_NOP, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
		word_q.push_back(mk(ACT_CLEAR, 0, 0, 26000, 0));
		word_q.push_back(mk(ACT_CLEAR, 0, 0, 32'h9000_0000, 0));
		word_q.push_back(mk(ACT_CLEAR, 0, 0, ALL_ONES, 0));
		word_q.push_back(mk(ACT_ADD, 0, 0, 0, 0));
		for (int i = 0; i < 50; i++) word_q.push_back(rand_word());
		drain();

		foreach (mss_set[p]) begin
			write_mss(mss_set[p]);
			for (int i = 0; i < 35; i++) word_q.push_back(rand_word());
			hold_off = 1;
			repeat ($urandom_range(0, 3)) @(posedge clk);
			hold_off = 0;
			for (int i = 0; i < 35; i++) word_q.push_back(rand_word());
			if (p == 1) begin
				@(posedge clk);
				hold_off = 1;
				while (want_q.size() > 0 || start) @(posedge clk);
				hold_off = 0;
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (!failed && want_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### files.f
design/srs_pkg.sv
design/srs_cell.sv
design/srs_div.sv
design/sack_range_scoreboard.sv
design/srs_checker.sv
sim/sack_range_scoreboard_tb.sv
